[src/positional_ordered_list_unit_defines.svh]
// assertion macros for the ordered list unit
`ifndef POSITIONAL_ORDERED_LIST_UNIT_DEFINES_SVH
`define POSITIONAL_ORDERED_LIST_UNIT_DEFINES_SVH

// same-cycle implication
`define POLU_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("list unit assertion failed");

// next-cycle implication
`define POLU_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("list unit assertion failed");

`endif

[src/polu_pkg.sv]
`default_nettype none

package polu_pkg;

	localparam int ACTION_W = 3;
	localparam int VALUE_W  = 32;
	localparam int POS_W    = 8;
	localparam int STATUS_W = 2;
	localparam int IN_W     = 48;

	localparam logic [ACTION_W-1:0] ACT_INS_FRONT = 3'd0;
	localparam logic [ACTION_W-1:0] ACT_INS_BACK  = 3'd1;
	localparam logic [ACTION_W-1:0] ACT_INS_AT    = 3'd2;
	localparam logic [ACTION_W-1:0] ACT_DEL_FRONT = 3'd3;
	localparam logic [ACTION_W-1:0] ACT_DEL_BACK  = 3'd4;
	localparam logic [ACTION_W-1:0] ACT_DEL_AT    = 3'd5;
	localparam logic [ACTION_W-1:0] ACT_SEARCH    = 3'd6;

	localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
	localparam logic [STATUS_W-1:0] ST_BADPOS = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;
	localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd3;

	typedef struct packed {
		logic ins;
		logic del;
		logic srch;
	} polu_cmd_t;

endpackage

`default_nettype wire

[src/polu_cell.sv]
`default_nettype none

module polu_cell import polu_pkg::*; #(
	parameter int INDEX = 0,
	parameter int IDX_W = 6,
	parameter int CNT_W = 7
) (
	input  wire logic                      clk,
	input  wire polu_cmd_t                 cmd,
	input  wire logic        [IDX_W-1:0]   idx,
	input  wire logic        [CNT_W-1:0]   count,
	input  wire logic signed [VALUE_W-1:0] key,
	input  wire logic signed [VALUE_W-1:0] left,
	input  wire logic signed [VALUE_W-1:0] right,
	output logic signed [VALUE_W-1:0]      value,
	output logic                           match
);

	localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);
	localparam logic [CNT_W-1:0] MY_CNT = CNT_W'(INDEX);

	logic signed [VALUE_W-1:0] value_q;
	logic                      match_q;

	always_ff @(posedge clk) begin
		if (cmd.ins) begin
			if (MY_IDX == idx) begin
				value_q <= key;
			end else if (MY_IDX > idx) begin
				value_q <= left;
			end
		end else if (cmd.del) begin
			if (MY_IDX >= idx) begin
				value_q <= right;
			end
		end
		if (cmd.srch) begin
			match_q <= (MY_CNT < count) && (value_q == key);
		end
	end

	assign value = value_q;
	assign match = match_q;

endmodule

`default_nettype wire

[src/polu_out_queue.sv]
`default_nettype none

module polu_out_queue #(
	parameter int W = 10
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push,
	input  wire logic [W-1:0] push_data,
	output logic              full,
	output logic              out_valid,
	input  wire logic         out_ready,
	output logic [W-1:0]      out_data
);

	logic [W-1:0] slot_q [2];
	logic         rd_q;
	logic         wr_q;
	logic [1:0]   cnt_q;
	logic         pop;

	assign pop       = out_valid && out_ready;
	assign full      = (cnt_q == 2'd2);
	assign out_valid = (cnt_q != 2'd0);
	assign out_data  = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q  <= 1'b0;
			wr_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

`default_nettype wire

[src/positional_ordered_list_unit.sv]
// positional ordered list unit
// input stream s_*: one transfer is one action (insert front/back/at position,
// delete front/back/at position, search); s_tdata holds action, value, position
// output stream m_*: one transfer per action with status, found flag and count
// the list is a row of cells, one per entry; inserts and deletes shift all
// cells at once in the cycle the action is accepted
// inserts, deletes and unused codes: result queued at the accept edge, so
// with a free output one action is taken every cycle
// search: cells compare at the accept edge, group or-stage next, final or
// after that; the result is queued as the final state ends, and the input
// is held off while the search is in the group and final states
// a two-entry output queue lets the next action enter while a result waits;
// when the receiver stalls and both entries are full, s_tready drops
// reset empties the list and the output queue; no clearing pass is needed
`default_nettype none
`include "positional_ordered_list_unit_defines.svh"

module positional_ordered_list_unit import polu_pkg::*; #(
	parameter int CAPACITY = 64
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                s_tvalid,
	output logic                     s_tready,
	// action [2:0], value [34:3], position [42:35]
	input  wire logic [IN_W-1:0]     s_tdata,
	output logic                     m_tvalid,
	input  wire logic                m_tready,
	// status [1:0], found [2], count [3 +: count width]
	output logic [((3 + $clog2(CAPACITY + 1) + 7) / 8) * 8 - 1:0] m_tdata
);

	localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;
	localparam int GRP   = 32;
	localparam int NGRP  = (CAPACITY + GRP - 1) / GRP;
	localparam int RES_W = STATUS_W + 1 + CNT_W;
	localparam int OUT_W = ((RES_W + 7) / 8) * 8;

	typedef enum logic [2:0] {
		S_IDLE  = 3'b001,
		S_GROUP = 3'b010,
		S_FINAL = 3'b100
	} fsm_t;

	fsm_t                      state_q;
	logic [CNT_W-1:0]          count_q;
	logic [NGRP-1:0]           grp_q;

	logic                      s_accept;
	logic [ACTION_W-1:0]       act;
	logic signed [VALUE_W-1:0] key;
	logic [POS_W-1:0]          pos;
	logic [CMP_W-1:0]          pos_w;
	logic [CMP_W-1:0]          cnt_w;
	logic                      is_full;
	logic                      is_empty;

	polu_cmd_t                 cmd_dec;
	polu_cmd_t                 cmd;
	logic [IDX_W-1:0]          idx;
	logic [STATUS_W-1:0]       status;
	logic [CNT_W-1:0]          cnt_next;

	logic signed [VALUE_W-1:0] cell_val [CAPACITY];
	logic [NGRP*GRP-1:0]       match_pad;

	logic                      q_full;
	logic                      push;
	logic [RES_W-1:0]          push_data;
	logic [RES_W-1:0]          q_data;

	assign act   = s_tdata[2:0];
	assign key   = s_tdata[34:3];
	assign pos   = s_tdata[42:35];
	assign pos_w = CMP_W'(pos);
	assign cnt_w = CMP_W'(count_q);

	assign is_full  = (count_q == CNT_W'(CAPACITY));
	assign is_empty = (count_q == '0);

	assign s_tready = (state_q == S_IDLE) && !q_full;
	assign s_accept = s_tvalid && s_tready;

	always_comb begin
		cmd_dec = '0;
		idx     = '0;
		status  = ST_OK;
		unique case (act) inside
			ACT_INS_FRONT, ACT_INS_BACK, ACT_INS_AT: begin
				if (is_full) begin
					status = ST_FULL;
				end else if (act == ACT_INS_FRONT) begin
					cmd_dec.ins = 1'b1;
				end else if (act == ACT_INS_BACK) begin
					cmd_dec.ins = 1'b1;
					idx         = IDX_W'(count_q);
				end else if (pos == '0 || pos_w > cnt_w + CMP_W'(1)) begin
					status = ST_BADPOS;
				end else begin
					cmd_dec.ins = 1'b1;
					idx         = IDX_W'(pos - POS_W'(1));
				end
			end
			ACT_DEL_FRONT, ACT_DEL_BACK, ACT_DEL_AT: begin
				if (is_empty) begin
					status = ST_EMPTY;
				end else if (act == ACT_DEL_FRONT) begin
					cmd_dec.del = 1'b1;
				end else if (act == ACT_DEL_BACK) begin
					cmd_dec.del = 1'b1;
					idx         = IDX_W'(count_q - CNT_W'(1));
				end else if (pos == '0 || pos_w > cnt_w) begin
					status = ST_BADPOS;
				end else begin
					cmd_dec.del = 1'b1;
					idx         = IDX_W'(pos - POS_W'(1));
				end
			end
			ACT_SEARCH: begin
				cmd_dec.srch = 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign cmd.ins  = cmd_dec.ins && s_accept;
	assign cmd.del  = cmd_dec.del && s_accept;
	assign cmd.srch = cmd_dec.srch && s_accept;

	always_comb begin
		cnt_next = count_q;
		if (cmd_dec.ins) begin
			cnt_next = count_q + CNT_W'(1);
		end else if (cmd_dec.del) begin
			cnt_next = count_q - CNT_W'(1);
		end
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic signed [VALUE_W-1:0] left_v;
		logic signed [VALUE_W-1:0] right_v;
		if (i == 0) begin : g_first
			assign left_v = key;
		end else begin : g_mid_l
			assign left_v = cell_val[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign right_v = cell_val[i];
		end else begin : g_mid_r
			assign right_v = cell_val[i+1];
		end
		polu_cell #(
			.INDEX (i),
			.IDX_W (IDX_W),
			.CNT_W (CNT_W)
		) u_cell (
			.clk   (clk),
			.cmd   (cmd),
			.idx   (idx),
			.count (count_q),
			.key   (key),
			.left  (left_v),
			.right (right_v),
			.value (cell_val[i]),
			.match (match_pad[i])
		);
	end

	if (NGRP * GRP > CAPACITY) begin : g_pad
		assign match_pad[NGRP*GRP-1:CAPACITY] = '0;
	end

	always_ff @(posedge clk) begin
		if (state_q == S_GROUP) begin
			for (int g = 0; g < NGRP; g++) begin
				grp_q[g] <= |match_pad[g*GRP +: GRP];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
		end else begin
			if (s_accept) begin
				count_q <= cnt_next;
			end
			unique case (state_q)
				S_IDLE: begin
					if (cmd.srch) begin
						state_q <= S_GROUP;
					end
				end
				S_GROUP: begin
					state_q <= S_FINAL;
				end
				S_FINAL: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_comb begin
		push      = 1'b0;
		push_data = {cnt_next, 1'b0, status};
		if (state_q == S_FINAL) begin
			push      = 1'b1;
			push_data = {count_q, |grp_q, ST_OK};
		end else if (s_accept && !cmd_dec.srch) begin
			push = 1'b1;
		end
	end

	polu_out_queue #(
		.W (RES_W)
	) u_out_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (q_full),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (q_data)
	);

	assign m_tdata = OUT_W'(q_data);

	`POLU_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CNT_W'(CAPACITY))
	`POLU_ASSERT_NOW(a_busy_holds_input, state_q != S_IDLE, !s_tready)
	`POLU_ASSERT_NEXT(a_search_starts, cmd.srch, state_q == S_GROUP)
	`POLU_ASSERT_NEXT(a_count_stable, !s_accept, $stable(count_q))
	`POLU_ASSERT_NOW(a_final_has_room, state_q == S_FINAL, !q_full)

endmodule

`default_nettype wire
